[hw/rtl/lif_neuron_array_update_unit_assert.svh]
// Assertion macros shared by the checker of the neuron array update unit.
`ifndef LIF_NEURON_ARRAY_UPDATE_UNIT_ASSERT_SVH
`define LIF_NEURON_ARRAY_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LNAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LNAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lnau_pkg.sv]
// Types and constants shared by the neuron array update unit.
`default_nettype none
package lnau_pkg;

    localparam logic [1:0] OP_INJECT = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_NOISE  = 2'd2;

    localparam logic [2:0] CFG_REST      = 3'd0;
    localparam logic [2:0] CFG_RESET     = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_MEM_DECAY = 3'd3;
    localparam logic [2:0] CFG_SYN_DECAY = 3'd4;
    localparam logic [2:0] CFG_REFRACT   = 3'd5;
    localparam logic [2:0] CFG_COUNT     = 3'd6;
    localparam logic [2:0] CFG_SEED      = 3'd7;

    localparam logic signed [15:0] REST_RESET      = -16'sd16640;
    localparam logic signed [15:0] RESET_RESET     = -16'sd16640;
    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd12800;
    localparam logic [15:0]        MEM_DECAY_RESET = 16'd62333;
    localparam logic [15:0]        SYN_DECAY_RESET = 16'd53656;
    localparam logic [7:0]         REFRACT_RESET   = 8'd2;
    localparam logic [12:0]        COUNT_RESET     = 13'd4096;
    localparam logic [31:0]        SEED_RESET      = 32'd2463534242;

    localparam logic [15:0] NOISE_AMOUNT = 16'd461;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        neuron_index;
        logic signed [15:0] current;
    } in_item_t;

    typedef struct packed {
        logic [11:0]        neuron_index_out;
        logic               spiked;
        logic signed [15:0] membrane_out;
        logic               status;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] rest;
        logic signed [15:0] reset_v;
        logic signed [15:0] threshold;
        logic [15:0]        mem_decay;
        logic [15:0]        syn_decay;
        logic [7:0]         refract;
        logic [12:0]        count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        neuron_index;
        logic signed [15:0] current;
        logic [31:0]        gen;
        logic               ignored;
    } q_item_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] g);
        logic [31:0] a;
        logic [31:0] b;
        a = g ^ (g << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lnau_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lnau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[hw/rtl/lnau_front.sv]
// Front end: configuration registers, noise generator, input accept and classify.
`default_nettype none
module lnau_front #(
    parameter int MAX_NEURONS = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lnau_pkg::in_item_t in_data,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               clearing,
    input  wire logic               q_ready,
    output logic                    q_valid,
    output lnau_pkg::q_item_t       q_data,
    output lnau_pkg::cfg_t          cfg
);

    logic signed [15:0] rest_reg;
    logic signed [15:0] reset_reg;
    logic signed [15:0] threshold_reg;
    logic [15:0]        mem_decay_reg;
    logic [15:0]        syn_decay_reg;
    logic [7:0]         refract_reg;
    logic [12:0]        count_reg;
    logic [31:0]        gen_reg;
    logic [31:0]        gen_next;
    logic [12:0]        count_eff;
    logic               accept;
    logic               out_of_range;

    assign count_eff = (32'(count_reg) > 32'(MAX_NEURONS)) ? 13'(MAX_NEURONS) : count_reg;
    assign in_ready  = !clearing && q_ready;
    assign accept    = in_valid && in_ready;
    assign gen_next  = lnau_pkg::xorshift32(gen_reg);
    assign out_of_range = {1'b0, in_data.neuron_index} >= count_eff;

    always_comb
    begin
        q_valid              = accept;
        q_data.opcode        = in_data.opcode;
        q_data.neuron_index  = in_data.neuron_index;
        q_data.current       = in_data.current;
        q_data.gen           = gen_next;
        unique case (in_data.opcode)
            lnau_pkg::OP_INJECT: q_data.ignored = out_of_range;
            lnau_pkg::OP_UPDATE: q_data.ignored = out_of_range;
            lnau_pkg::OP_NOISE:  q_data.ignored = (count_eff == 13'd0);
            default:             q_data.ignored = 1'b1;
        endcase
    end

    always_comb
    begin
        cfg.rest      = rest_reg;
        cfg.reset_v   = reset_reg;
        cfg.threshold = threshold_reg;
        cfg.mem_decay = mem_decay_reg;
        cfg.syn_decay = syn_decay_reg;
        cfg.refract   = refract_reg;
        cfg.count     = count_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg      <= lnau_pkg::REST_RESET;
            reset_reg     <= lnau_pkg::RESET_RESET;
            threshold_reg <= lnau_pkg::THRESHOLD_RESET;
            mem_decay_reg <= lnau_pkg::MEM_DECAY_RESET;
            syn_decay_reg <= lnau_pkg::SYN_DECAY_RESET;
            refract_reg   <= lnau_pkg::REFRACT_RESET;
            count_reg     <= lnau_pkg::COUNT_RESET;
            gen_reg       <= lnau_pkg::SEED_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lnau_pkg::CFG_REST:      rest_reg      <= cfg_data[15:0];
                    lnau_pkg::CFG_RESET:     reset_reg     <= cfg_data[15:0];
                    lnau_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[15:0];
                    lnau_pkg::CFG_MEM_DECAY: mem_decay_reg <= cfg_data[15:0];
                    lnau_pkg::CFG_SYN_DECAY: syn_decay_reg <= cfg_data[15:0];
                    lnau_pkg::CFG_REFRACT:   refract_reg   <= cfg_data[7:0];
                    lnau_pkg::CFG_COUNT:     count_reg     <= cfg_data[12:0];
                    lnau_pkg::CFG_SEED:      gen_reg       <= cfg_data;
                    default:                 rest_reg      <= rest_reg;
                endcase
            end
            else if (accept && in_data.opcode == lnau_pkg::OP_NOISE)
            begin
                gen_reg <= gen_next;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lnau_fifo.sv]
// Two-entry queue between the front end and the back end.
`default_nettype none
module lnau_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   push_ready,
    input  wire lnau_pkg::q_item_t push_data,
    input  wire logic              pop,
    output logic                   pop_valid,
    output lnau_pkg::q_item_t      pop_data
);

    lnau_pkg::q_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && push_ready)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push && push_ready) - 2'(pop && pop_valid);
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lnau_back.sv]
// Back end: clearing pass, modulo unit, per-neuron read-modify-write and result register.
`default_nettype none
module lnau_back #(
    parameter int MAX_NEURONS = 4096,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lnau_pkg::cfg_t    cfg,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire lnau_pkg::q_item_t q_data,
    output logic                   clearing,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lnau_pkg::out_item_t    out_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int WW = 56;
    localparam int RW = 3 * VW + 8;
    localparam logic signed [WW-1:0] VMAX = WW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] VMIN = -VMAX - WW'(1);
    localparam logic signed [WW-1:0] RND  = WW'(32768);
    localparam logic [AW-1:0]        LAST = AW'(MAX_NEURONS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [WW-1:0] x);
        if (x > VMAX)
        begin
            return VW'(VMAX);
        end
        if (x < VMIN)
        begin
            return VW'(VMIN);
        end
        return VW'(x);
    endfunction

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [AW-1:0]       clr_cnt_reg;
    lnau_pkg::q_item_t   item_reg;
    logic [AW-1:0]       addr_reg;
    logic [31:0]         dvd_reg;
    logic [12:0]         rem_reg;
    logic [4:0]          bit_cnt_reg;
    logic [RW-1:0]       word_reg;
    logic signed [WW-1:0] prod_syn_reg;
    logic signed [WW-1:0] prod_mem_reg;
    lnau_pkg::out_item_t res_reg;
    lnau_pkg::out_item_t out_data_reg;
    logic                out_valid_reg;

    logic [RW-1:0]       rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [RW-1:0]       wr_data;
    logic [RW-1:0]       init_word;
    logic [13:0]         rem_shift;
    logic [12:0]         rem_step;

    logic signed [VW-1:0] rd_mem;
    logic signed [VW-1:0] rd_syn;
    logic signed [VW-1:0] w_mem;
    logic signed [VW-1:0] w_syn;
    logic signed [VW-1:0] w_pend;
    logic [7:0]           w_ref;
    logic signed [VW-1:0] syn_new;
    logic signed [VW-1:0] v_int;
    logic signed [VW-1:0] v_new;
    logic signed [VW-1:0] reset_sat;
    logic signed [VW-1:0] pend_new;
    logic [7:0]           ref_new;
    logic                 spike;
    lnau_pkg::out_item_t  wb_res;
    logic [RW-1:0]        wb_word;

    lnau_ram #(.WIDTH(RW), .DEPTH(MAX_NEURONS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign init_word = {8'd0, {VW{1'b0}}, {VW{1'b0}}, sat_v(WW'(lnau_pkg::REST_RESET))};
    assign rd_mem = rd_data[VW-1:0];
    assign rd_syn = rd_data[2*VW-1:VW];
    assign w_mem  = word_reg[VW-1:0];
    assign w_syn  = word_reg[2*VW-1:VW];
    assign w_pend = word_reg[3*VW-1:2*VW];
    assign w_ref  = word_reg[RW-1:3*VW];

    assign rem_shift = {rem_reg, dvd_reg[31]};
    assign rem_step  = (rem_shift >= {1'b0, cfg.count}) ? 13'(rem_shift - {1'b0, cfg.count})
                                                         : rem_shift[12:0];

    always_comb
    begin
        reset_sat = sat_v(WW'(cfg.reset_v));
        syn_new   = sat_v((prod_syn_reg >>> 16) + WW'(w_pend));
        v_int     = sat_v(WW'(cfg.rest) + (prod_mem_reg >>> 16) + WW'(syn_new));
        spike     = 1'b0;
        v_new     = v_int;
        ref_new   = w_ref;
        pend_new  = w_pend;
        wb_word   = word_reg;
        wb_res.neuron_index_out = item_reg.neuron_index;
        wb_res.spiked           = 1'b0;
        wb_res.membrane_out     = 16'sd0;
        wb_res.status           = 1'b0;
        unique case (item_reg.opcode)
            lnau_pkg::OP_UPDATE:
            begin
                if (w_ref != 8'd0)
                begin
                    ref_new = w_ref - 8'd1;
                    v_new   = reset_sat;
                end
                else if (WW'(v_int) >= WW'(cfg.threshold))
                begin
                    ref_new = cfg.refract;
                    v_new   = reset_sat;
                    spike   = 1'b1;
                end
                wb_word = {ref_new, {VW{1'b0}}, syn_new, v_new};
                wb_res.spiked       = spike;
                wb_res.membrane_out = 16'(v_new);
            end
            lnau_pkg::OP_NOISE:
            begin
                pend_new = sat_v(WW'(w_pend) + WW'(lnau_pkg::NOISE_AMOUNT));
                wb_word  = {w_ref, pend_new, w_syn, w_mem};
                wb_res.neuron_index_out = 12'(addr_reg);
            end
            default:
            begin
                pend_new = sat_v(WW'(w_pend) + WW'(item_reg.current));
                wb_word  = {w_ref, pend_new, w_syn, w_mem};
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = wb_word;
        if (state_reg == S_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = init_word;
        end
        else if (state_reg == S_WB)
        begin
            wr_en = 1'b1;
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign clearing  = (state_reg == S_CLR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.ignored)
                    begin
                        state_next = S_RES;
                    end
                    else if (q_data.opcode == lnau_pkg::OP_NOISE)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_DIV:
            begin
                if (bit_cnt_reg == 5'd31)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:  state_next = S_MUL;
            S_MUL: state_next = S_WB;
            S_WB:  state_next = S_RES;
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            item_reg <= q_data;
            addr_reg <= AW'(q_data.neuron_index);
            dvd_reg  <= q_data.gen;
            rem_reg  <= 13'd0;
            res_reg.neuron_index_out <= (q_data.opcode == lnau_pkg::OP_NOISE)
                                        ? 12'd0 : q_data.neuron_index;
            res_reg.spiked       <= 1'b0;
            res_reg.membrane_out <= 16'sd0;
            res_reg.status       <= 1'b1;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (bit_cnt_reg == 5'd31)
            begin
                addr_reg <= AW'(rem_step);
            end
        end
        if (state_reg == S_MUL)
        begin
            word_reg     <= rd_data;
            prod_syn_reg <= WW'(rd_syn) * $signed(WW'({1'b0, cfg.syn_decay})) + RND;
            prod_mem_reg <= (WW'(rd_mem) - WW'(cfg.rest)) *
                            $signed(WW'({1'b0, cfg.mem_decay})) + RND;
        end
        if (state_reg == S_WB)
        begin
            res_reg <= wb_res;
        end
        if (state_reg == S_RES && (!out_valid_reg || out_ready))
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            bit_cnt_reg   <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == S_DIV)
            begin
                bit_cnt_reg <= bit_cnt_reg + 5'd1;
            end
            else
            begin
                bit_cnt_reg <= 5'd0;
            end
            if (state_reg == S_RES && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lif_neuron_array_update_unit.sv]
// Top level of the leaky integrate-and-fire neuron array update unit.
//
// Input channel in_valid/in_ready carries one item: opcode (inject, update,
// noise), neuron index and inject current. Output channel out_valid/out_ready
// returns exactly one result item per input item, in order. The cfg channel
// writes register cfg_index with cfg_data; cfg_ready is always high.
// Inject and update pass through the queue hand-off, the memory read, the
// product register and the write-back step before out_valid rises. Noise
// first runs a bit-serial remainder unit to pick the random target, and
// ignored items go from the queue straight to the result step. The
// back end works on one item at a time. After reset a clearing pass writes
// every neuron entry with in_ready low; configuration writes are taken
// during it. A two-entry queue decouples acceptance from processing, so
// the input side keeps taking items while the result register waits, until
// the queue is full. If the receiver stalls, the result holds and the back
// end stops at its next result.
`default_nettype none
module lif_neuron_array_update_unit #(
    parameter int MAX_NEURONS = 4096,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lnau_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lnau_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    lnau_pkg::q_item_t push_data;
    lnau_pkg::q_item_t pop_data;
    lnau_pkg::cfg_t    cfg;
    logic              push;
    logic              push_ready;
    logic              pop;
    logic              pop_valid;
    logic              clearing;

    assign cfg_ready = 1'b1;

    lnau_front #(.MAX_NEURONS(MAX_NEURONS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .q_ready   (push_ready),
        .q_valid   (push),
        .q_data    (push_data),
        .cfg       (cfg)
    );

    lnau_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    lnau_back #(.MAX_NEURONS(MAX_NEURONS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (pop_valid),
        .q_pop     (pop),
        .q_data    (pop_data),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[hw/rtl/lnau_checker.sv]
// Port-level checker for the neuron array update unit, with its bind.
`default_nettype none
`include "lif_neuron_array_update_unit_assert.svh"
module lnau_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire lnau_pkg::out_item_t out_data
);

    `LNAU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
    `LNAU_ASSERT_IMP(a_ignored_clean, clk, rst_n, out_valid && out_data.status, !out_data.spiked && out_data.membrane_out == 16'sd0, "ignored item carries data")
    `LNAU_ASSERT_IMP(a_spike_done, clk, rst_n, out_valid && out_data.spiked, !out_data.status, "spike reported on ignored item")

endmodule

bind lif_neuron_array_update_unit lnau_checker u_lnau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
